/* src/dwc_pkg.sv */
// Package with sizes, codes, types and helpers for the depthwise 5x5 convolution unit.
package dwc_pkg;

  localparam int PLANE_SIZE  = 26;
  localparam int CHANNELS    = 64;
  localparam int KSIZE       = 5;
  localparam int TAPS        = KSIZE * KSIZE;
  localparam int COEFF_DEPTH = (TAPS + 1) * CHANNELS;
  localparam int COEFF_AW    = $clog2(COEFF_DEPTH);
  localparam int ROW_DEPTH   = KSIZE * PLANE_SIZE;
  localparam int ROW_AW      = $clog2(ROW_DEPTH);
  localparam int POS_W       = $clog2(PLANE_SIZE + 1);
  localparam int SLOT_W      = 3;
  localparam int KIDX_W      = 3;
  localparam int TAP_W       = 5;
  localparam int CH_W        = 6;
  localparam int VAL_W       = 16;
  localparam int RES_W       = 15;
  localparam int ACC_W       = 37;
  localparam int FRAC_SHIFT  = 14;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef struct packed {
    logic valid;
    logic clear;
    logic pad;
    logic bias;
  } mac_ctl_t;

  // Line-buffer slot of row (slot row + kh - 2), all taken modulo the kernel size.
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] slot,
                                                 input logic [KIDX_W-1:0] kh);
    logic [3:0] s;
    s = 4'(slot) + 4'(kh) + 4'(KSIZE - 2);
    if (s >= 4'(2 * KSIZE)) begin
      s = s - 4'(2 * KSIZE);
    end else if (s >= 4'(KSIZE)) begin
      s = s - 4'(KSIZE);
    end
    return s[SLOT_W-1:0];
  endfunction

endpackage

/* src/dwc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module dwc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* src/dwc_mac.sv */
// Multiply-accumulate datapath with rounding, ReLU and saturation.
module dwc_mac import dwc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_ctl_t                ctl,
  input  logic signed [VAL_W-1:0] coeff,
  input  logic signed [VAL_W-1:0] pix,
  output logic [RES_W-1:0]        result
);

  mac_ctl_t                ctl_d_r;
  logic                    prod_v_r;
  logic signed [ACC_W-1:0] prod_r;
  logic signed [ACC_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] rnd;
  logic [ACC_W-FRAC_SHIFT-1:0] q;

  always_comb begin
    if (ctl_d_r.bias) begin
      prod_nxt = ACC_W'(coeff) <<< FRAC_SHIFT;
    end else if (ctl_d_r.pad) begin
      prod_nxt = '0;
    end else begin
      prod_nxt = ACC_W'(coeff * pix);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d_r  <= '0;
      prod_v_r <= 1'b0;
    end else begin
      ctl_d_r  <= ctl;
      prod_v_r <= ctl_d_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + prod_r;
    end
  end

  assign rnd = acc_r + ACC_W'(1 << (FRAC_SHIFT - 1));
  assign q   = rnd[ACC_W-1:FRAC_SHIFT];

  always_comb begin
    if (rnd[ACC_W-1]) begin
      result = '0;
    end else if (|q[ACC_W-FRAC_SHIFT-1:RES_W]) begin
      result = '1;
    end else begin
      result = q[RES_W-1:0];
    end
  end

endmodule

/* src/depthwise_conv5x5_relu_unit.sv */
// Top level of the depthwise 5x5 convolution unit with bias and ReLU.
//
// Channel   Direction  Contents
// in_*      request    tuser: cmd; tdata: channel, tap, value
// out_*     result     tlast: plane_done; tdata: out_channel, out_row, out_col, out_value
//
// For each output that a pixel releases, one multiplier walks the 25 taps and the
// bias, one coefficient and one line-buffer word read from the two RAMs per cycle.
// The last pixel of a plane releases 2*PLANE_SIZE+3 outputs.
// Reset clears the pixel and output positions; the RAMs hold no reset value.
// A stalled output holds the datapath only in the cycle that hands a result over.
module depthwise_conv5x5_relu_unit import dwc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // channel[5:0], tap[10:6], value[26:11], zero fill
  input  logic        in_tuser,  // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // out_channel[5:0], out_row[10:6], out_col[15:11],
                                 // out_value[30:16], zero fill
  output logic        out_tlast
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FINAL = 3'd4;
  localparam int PW = POS_W + 2;

  logic [2:0]        state_r, state_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [POS_W-1:0]  prow_r, prow_nxt, pcol_r, pcol_nxt;
  logic [POS_W-1:0]  erow_r, erow_nxt, ecol_r, ecol_nxt;
  logic [SLOT_W-1:0] pslot_r, pslot_nxt, eslot_r, eslot_nxt;
  logic [TAP_W-1:0]  tap_r, tap_nxt;
  logic [KIDX_W-1:0] kh_r, kh_nxt, kw_r, kw_nxt;
  logic              drain_r, drain_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_data_r;
  logic              out_last_r;

  logic [CH_W-1:0]   in_ch;
  logic [TAP_W-1:0]  in_tap;
  logic [VAL_W-1:0]  in_val;
  logic              accept, load_out, emit_ready;
  logic              cf_we, row_we;
  logic [COEFF_AW-1:0] cf_waddr, cf_raddr;
  logic [ROW_AW-1:0]   row_waddr, row_raddr;
  logic [VAL_W-1:0]    cf_rdata, row_rdata;
  logic [POS_W:0]      need_row, need_col;
  logic signed [PW-1:0] pr_s, pc_s;
  logic                 pad;
  mac_ctl_t             mac_ctl;
  logic [RES_W-1:0]     mac_res;

  function automatic logic [POS_W:0] lim(input logic [POS_W-1:0] v);
    logic [POS_W:0] s;
    s = (POS_W + 1)'(v) + (POS_W + 1)'(2);
    if (s > (POS_W + 1)'(PLANE_SIZE - 1)) begin
      s = (POS_W + 1)'(PLANE_SIZE - 1);
    end
    return s;
  endfunction

  assign in_ch   = in_tdata[5:0];
  assign in_tap  = in_tdata[10:6];
  assign in_val  = in_tdata[26:11];
  assign in_tready = (state_r == ST_IDLE);
  assign accept  = in_tvalid && in_tready;

  assign cf_we     = accept && (in_tuser == CMD_LOAD) && (int'(in_tap) <= TAPS)
                     && (int'(in_ch) < CHANNELS);
  assign cf_waddr  = COEFF_AW'(in_ch) * COEFF_AW'(TAPS + 1) + COEFF_AW'(in_tap);
  assign row_we    = accept && (in_tuser == CMD_PIXEL);
  assign row_waddr = ROW_AW'(pslot_r) * ROW_AW'(PLANE_SIZE) + ROW_AW'(pcol_r);

  assign pr_s = PW'(erow_r) + PW'(kh_r) - PW'(2);
  assign pc_s = PW'(ecol_r) + PW'(kw_r) - PW'(2);
  assign pad  = pr_s[PW-1] || (pr_s >= PW'(PLANE_SIZE)) ||
                pc_s[PW-1] || (pc_s >= PW'(PLANE_SIZE));
  assign cf_raddr  = COEFF_AW'(ch_r) * COEFF_AW'(TAPS + 1) + COEFF_AW'(tap_r);
  assign row_raddr = ROW_AW'(slot_add(eslot_r, kh_r)) * ROW_AW'(PLANE_SIZE) +
                     ROW_AW'(pc_s[POS_W-1:0]);

  assign mac_ctl.valid = (state_r == ST_MAC);
  assign mac_ctl.clear = (state_r == ST_MAC) && (tap_r == '0);
  assign mac_ctl.bias  = (int'(tap_r) == TAPS);
  assign mac_ctl.pad   = pad;

  assign need_row   = lim(erow_r);
  assign need_col   = lim(ecol_r);
  assign emit_ready = (int'(erow_r) < PLANE_SIZE) &&
                      ((need_row < (POS_W + 1)'(prow_r)) ||
                       ((need_row == (POS_W + 1)'(prow_r)) &&
                        (need_col <= (POS_W + 1)'(pcol_r))));
  assign load_out   = (state_r == ST_FINAL) && (!out_valid_r || out_tready);

  dwc_ram #(.WIDTH(VAL_W), .DEPTH(COEFF_DEPTH)) u_coeff_ram (
    .clk     (clk),
    .wr_en   (cf_we),
    .wr_addr (cf_waddr),
    .wr_data (in_val),
    .rd_addr (cf_raddr),
    .rd_data (cf_rdata)
  );

  dwc_ram #(.WIDTH(VAL_W), .DEPTH(ROW_DEPTH)) u_row_ram (
    .clk     (clk),
    .wr_en   (row_we),
    .wr_addr (row_waddr),
    .wr_data (in_val),
    .rd_addr (row_raddr),
    .rd_data (row_rdata)
  );

  dwc_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .coeff  (cf_rdata),
    .pix    (row_rdata),
    .result (mac_res)
  );

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    prow_nxt  = prow_r;
    pcol_nxt  = pcol_r;
    pslot_nxt = pslot_r;
    erow_nxt  = erow_r;
    ecol_nxt  = ecol_r;
    eslot_nxt = eslot_r;
    tap_nxt   = tap_r;
    kh_nxt    = kh_r;
    kw_nxt    = kw_r;
    drain_nxt = drain_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_tuser == CMD_PIXEL)) begin
          ch_nxt    = in_ch;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (emit_ready) begin
          tap_nxt   = '0;
          kh_nxt    = '0;
          kw_nxt    = '0;
          state_nxt = ST_MAC;
        end else begin
          state_nxt = ST_IDLE;
          if (int'(pcol_r) == PLANE_SIZE - 1) begin
            pcol_nxt = '0;
            if (int'(prow_r) == PLANE_SIZE - 1) begin
              prow_nxt  = '0;
              pslot_nxt = '0;
              erow_nxt  = '0;
              ecol_nxt  = '0;
              eslot_nxt = '0;
            end else begin
              prow_nxt  = prow_r + 1'b1;
              pslot_nxt = (int'(pslot_r) == KSIZE - 1) ? '0 : pslot_r + 1'b1;
            end
          end else begin
            pcol_nxt = pcol_r + 1'b1;
          end
        end
      end
      ST_MAC: begin
        tap_nxt = tap_r + 1'b1;
        if (int'(kw_r) == KSIZE - 1) begin
          kw_nxt = '0;
          kh_nxt = kh_r + 1'b1;
        end else begin
          kw_nxt = kw_r + 1'b1;
        end
        if (int'(tap_r) == TAPS) begin
          drain_nxt = 1'b0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (load_out) begin
          state_nxt = ST_CHECK;
          if (int'(ecol_r) == PLANE_SIZE - 1) begin
            ecol_nxt  = '0;
            erow_nxt  = erow_r + 1'b1;
            eslot_nxt = (int'(eslot_r) == KSIZE - 1) ? '0 : eslot_r + 1'b1;
          end else begin
            ecol_nxt = ecol_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prow_r      <= '0;
      pcol_r      <= '0;
      pslot_r     <= '0;
      erow_r      <= '0;
      ecol_r      <= '0;
      eslot_r     <= '0;
      tap_r       <= '0;
      kh_r        <= '0;
      kw_r        <= '0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prow_r      <= prow_nxt;
      pcol_r      <= pcol_nxt;
      pslot_r     <= pslot_nxt;
      erow_r      <= erow_nxt;
      ecol_r      <= ecol_nxt;
      eslot_r     <= eslot_nxt;
      tap_r       <= tap_nxt;
      kh_r        <= kh_nxt;
      kw_r        <= kw_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r <= ch_nxt;
    if (load_out) begin
      out_data_r <= {1'b0, mac_res, 5'(ecol_r), 5'(erow_r), ch_r};
      out_last_r <= (int'(erow_r) == PLANE_SIZE - 1) && (int'(ecol_r) == PLANE_SIZE - 1);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINAL)
    else $error("result register loaded outside the final step");
  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MAC |-> int'(tap_r) <= TAPS)
    else $error("tap counter ran past the bias tap");
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |->
      out_tdata[10:6] == 5'(PLANE_SIZE - 1) && out_tdata[15:11] == 5'(PLANE_SIZE - 1))
    else $error("plane end flagged away from the last position");
`endif

endmodule

/* tb/sv/dwc_checker.sv */
// Checker that predicts and compares the results of the depthwise 5x5 convolution unit.
`timescale 1ns / 100ps
module dwc_checker import dwc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [5:0]  ch;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [14:0] val;
    logic        done;
  } pix_out_t;

  logic signed [15:0] weights [COEFF_DEPTH];
  logic signed [15:0] lines [ROW_DEPTH];
  int pix_r, pix_c, emit_r, emit_c;
  pix_out_t outputs_due[$];

  assign pending = outputs_due.size();

  function automatic int clamp_pos(int v);
    return (v > PLANE_SIZE - 1) ? PLANE_SIZE - 1 : v;
  endfunction

  function automatic logic [14:0] relu_conv(int ch, int r, int c);
    longint acc;
    int pr, pc;
    acc = longint'(weights[ch * (TAPS + 1) + TAPS]) * 16384;
    for (int kh = 0; kh < KSIZE; kh++) begin
      pr = r + kh - 2;
      if (pr < 0 || pr >= PLANE_SIZE) continue;
      for (int kw = 0; kw < KSIZE; kw++) begin
        pc = c + kw - 2;
        if (pc < 0 || pc >= PLANE_SIZE) continue;
        acc += longint'(weights[ch * (TAPS + 1) + kh * KSIZE + kw]) *
               longint'(lines[(pr % KSIZE) * PLANE_SIZE + pc]);
      end
    end
    acc += 8192;
    if (acc <= 0) return '0;
    acc = acc >>> FRAC_SHIFT;
    return (acc > 32767) ? 15'h7fff : acc[14:0];
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  task automatic take_request(logic cmd, logic [5:0] ch, logic [4:0] tap, logic [15:0] v);
    pix_out_t o;
    int cur;
    if (cmd == CMD_LOAD) begin
      if (ch < CHANNELS && tap <= TAPS) weights[ch * (TAPS + 1) + tap] = v;
      return;
    end
    lines[(pix_r % KSIZE) * PLANE_SIZE + pix_c] = v;
    cur = pix_r * PLANE_SIZE + pix_c;
    while (emit_r < PLANE_SIZE &&
           clamp_pos(emit_r + 2) * PLANE_SIZE + clamp_pos(emit_c + 2) <= cur) begin
      o.ch = ch;
      o.row = emit_r[4:0];
      o.col = emit_c[4:0];
      o.val = (ch < CHANNELS) ? relu_conv(ch, emit_r, emit_c) : '0;
      o.done = (emit_r == PLANE_SIZE - 1) && (emit_c == PLANE_SIZE - 1);
      outputs_due.push_back(o);
      emit_c++;
      if (emit_c >= PLANE_SIZE) begin
        emit_c = 0;
        emit_r++;
      end
    end
    pix_c++;
    if (pix_c >= PLANE_SIZE) begin
      pix_c = 0;
      pix_r++;
      if (pix_r >= PLANE_SIZE) begin
        pix_r = 0;
        emit_r = 0;
        emit_c = 0;
      end
    end
  endtask

  initial begin
    fail_count = 0;
    pix_r = 0; pix_c = 0; emit_r = 0; emit_c = 0;
  end

  always @(posedge clk) begin
    pix_out_t want;
    if (rst_n && in_tvalid && in_tready)
      take_request(in_tuser, in_tdata[5:0], in_tdata[10:6], in_tdata[26:11]);
    if (rst_n && out_tvalid && out_tready) begin
      if (outputs_due.size() == 0) begin
        report("unexpected result", out_tdata, 0);
      end else begin
        want = outputs_due.pop_front();
        if (out_tdata[5:0] != want.ch) report("channel", out_tdata[5:0], want.ch);
        if (out_tdata[10:6] != want.row) report("row", out_tdata[10:6], want.row);
        if (out_tdata[15:11] != want.col) report("col", out_tdata[15:11], want.col);
        if (out_tdata[30:16] != want.val) report("value", out_tdata[30:16], want.val);
        if (out_tlast != want.done) report("plane_done", out_tlast, want.done);
      end
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// Top of the testbench: stimulus and verdict for the depthwise 5x5 convolution unit.
`timescale 1ns / 100ps
module tb_top;
  import dwc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  int          fail_count;
  int          pending;
  int          hold_cycles = 0;
  logic [5:0]  plane_ch;
  int          gap_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  depthwise_conv5x5_relu_unit u_top (.*);

  dwc_checker u_chk (.*);

  // Receiver stall pattern with a single long hold-off.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send(logic cmd, logic [5:0] ch, logic [4:0] tap, logic [15:0] v);
    if (gap_left > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap_left) @(posedge clk);
    end
    if ($urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 6);
    else gap_left = 0;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {5'b0, v, tap, ch};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic load_channel(logic [5:0] ch, int kind);
    logic [15:0] v;
    for (int t = 0; t <= TAPS; t++) begin
      case (kind)
        0: v = 16'h7fff;
        1: v = 16'h8000;
        default: v = (t == TAPS) ? 16'($urandom_range(0, 65535)) >>> 4
                                 : 16'($urandom_range(0, 65535));
      endcase
      send(CMD_LOAD, ch, t[4:0], v);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    gap_left = 0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    logic [15:0] v;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Pixels only use channels 0 to 2, and all of them get coefficients.
    for (int c = 0; c < 3; c++) load_channel(c[5:0], c);
    // Ignored loads: tap above the bias.
    send(CMD_LOAD, 6'd3, 5'd26, 16'h1234);
    send(CMD_LOAD, 6'd3, 5'd31, 16'hffff);
    drain();
    // Saturating channel with extreme pixels; long receiver hold-off once outputs flow.
    for (int i = 0; i < 70; i++) begin
      v = (i % 3 == 0) ? 16'h7fff : (i % 3 == 1 ? 16'h8000 : 16'($urandom_range(0, 65535)));
      if (i == 56) hold_cycles = 400;
      send(CMD_PIXEL, 6'd0, 5'($urandom_range(0, 31)), v);
    end
    drain();
    // Rest of the run: channel changes within the plane, random content.
    plane_ch = 6'd1;
    for (int i = 0; i < 70; i++) begin
      if ($urandom_range(0, 8) == 0) plane_ch = 6'($urandom_range(0, 2));
      v = 16'($signed(16'($urandom_range(0, 65535))) >>> $urandom_range(0, 12));
      send(CMD_PIXEL, plane_ch, 5'($urandom_range(0, 31)), v);
    end
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
src/dwc_pkg.sv
src/dwc_ram.sv
src/dwc_mac.sv
src/depthwise_conv5x5_relu_unit.sv
tb/sv/dwc_checker.sv
tb/sv/tb_top.sv
